// ----- design/iis_pkg.sv -----
// Shared types, sizes and helper functions for the streaming integral image core.
// Used by every module of the block but iis_ram; depends on nothing else.
`timescale 1ns / 1ps

package iis_pkg;

	// Image bounds and field widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int SIZE_W     = 11;
	localparam int PIXEL_W    = 8;
	localparam int VALUE_W    = 28;
	localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PIXEL_MAX  = (1 << PIXEL_W) - 1;
	localparam int ROWSUM_W   = $clog2(MAX_WIDTH * PIXEL_MAX + 1);

	// Queue sizes
	localparam int CQ_DEPTH  = 4;
	localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// One classified pixel, handed from the front to the back
	typedef struct packed {
		logic [ROWSUM_W-1:0] row_sum;
		logic [COL_W-1:0]    col;
		logic                first_row;
		logic                last;
	} cmd_t;

	// Front-to-queue write beat
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	// One result beat
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} res_t;

	// Last column index for a width register value: 0 acts as 1, large values clamp
	function automatic logic [COL_W-1:0] col_limit(input logic [SIZE_W-1:0] size);
		logic [COL_W-1:0] lim;
		if (size == '0) begin
			lim = '0;
		end else if (int'(size) > MAX_WIDTH) begin
			lim = COL_W'(MAX_WIDTH - 1);
		end else begin
			lim = COL_W'(size - 1'b1);
		end
		return lim;
	endfunction

	// Last row index for a height register value
	function automatic logic [ROW_W-1:0] row_limit(input logic [SIZE_W-1:0] size);
		logic [ROW_W-1:0] lim;
		if (size == '0) begin
			lim = '0;
		end else if (int'(size) > MAX_HEIGHT) begin
			lim = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			lim = ROW_W'(size - 1'b1);
		end
		return lim;
	endfunction

endpackage

// ----- design/integral_image_stream_core.sv -----
// Top level of the streaming integral image core: configuration registers and wiring.
// Depends on iis_pkg, iis_front, iis_cmd_queue, iis_back, iis_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  pixels in | push / full            | pixel[7:0]
//  results   | empty / pop            | integral_value[27:0], frame_last
//  config    | psel, penable, pwrite  | paddr[2:0], pwdata, prdata
//
// One pixel per cycle sustained while pop keeps up; each result passes through the command
// queue, then the line store read with add and write-back, before the result queue.
// The 1024-entry line store has one read and one write port; a same-address
// write on the read edge is bypassed from a register.
// Reset clears counters, row sum and queues; the line store is not cleared.
// Input stalls (full) only when the result queue backs up because pop is held low.
`timescale 1ns / 1ps

module integral_image_stream_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [iis_pkg::PIXEL_W-1:0]    pixel,
	output logic                           empty,
	input  logic                           pop,
	output logic [iis_pkg::VALUE_W-1:0]    integral_value,
	output logic                           frame_last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [iis_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [iis_pkg::APB_DATA_W-1:0] pwdata,
	output logic [iis_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	logic [iis_pkg::SIZE_W-1:0] width_q;
	logic [iis_pkg::SIZE_W-1:0] height_q;
	iis_pkg::reg_idx_t          reg_idx;
	logic                       reg_wr;

	iis_pkg::cmd_beat_t         front_beat;
	iis_pkg::cmd_t              q_cmd;
	logic                       q_empty;
	logic                       q_pop;

	// Register decode
	always_comb begin
		pready  = 1'b1;
		reg_idx = iis_pkg::reg_idx_t'(paddr[2]);
		reg_wr  = psel && penable && pwrite && pready;
		unique case (reg_idx)
			iis_pkg::REG_IMAGE_WIDTH:  prdata = iis_pkg::APB_DATA_W'(width_q);
			iis_pkg::REG_IMAGE_HEIGHT: prdata = iis_pkg::APB_DATA_W'(height_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= iis_pkg::SIZE_W'(1024);
			height_q <= iis_pkg::SIZE_W'(1024);
		end else if (reg_wr) begin
			unique case (reg_idx)
				iis_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[iis_pkg::SIZE_W-1:0];
				iis_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[iis_pkg::SIZE_W-1:0];
				default:                   width_q  <= width_q;
			endcase
		end
	end

	iis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pixel      (pixel),
		.q_full     (full),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.beat       (front_beat)
	);

	iis_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_beat (front_beat),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_cmd),
		.empty   (q_empty)
	);

	iis_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (q_cmd),
		.cmd_empty      (q_empty),
		.cmd_pop        (q_pop),
		.pop            (pop),
		.empty          (empty),
		.integral_value (integral_value),
		.frame_last     (frame_last)
	);

endmodule

// ----- design/iis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/iis_front.sv -----
// Front end: accepts pixels, tracks column and row, keeps the row running sum.
// Depends on iis_pkg; feeds iis_cmd_queue.
`timescale 1ns / 1ps

module iis_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [iis_pkg::PIXEL_W-1:0] pixel,
	input  logic                        q_full,
	input  logic [iis_pkg::SIZE_W-1:0]  width_cfg,
	input  logic [iis_pkg::SIZE_W-1:0]  height_cfg,
	output iis_pkg::cmd_beat_t          beat
);

	logic [iis_pkg::COL_W-1:0]    col_q;
	logic [iis_pkg::ROW_W-1:0]    row_q;
	logic [iis_pkg::ROWSUM_W-1:0] row_sum_q;

	logic                         take;
	logic [iis_pkg::COL_W-1:0]    col_lim;
	logic [iis_pkg::ROW_W-1:0]    row_lim;
	logic                         row_end;
	logic                         frame_end;
	logic [iis_pkg::ROWSUM_W-1:0] pixel_ext;
	logic [iis_pkg::ROWSUM_W-1:0] row_sum_next;

	// Classify the incoming beat
	always_comb begin
		take         = push && !q_full;
		col_lim      = iis_pkg::col_limit(width_cfg);
		row_lim      = iis_pkg::row_limit(height_cfg);
		row_end      = (col_q >= col_lim);
		frame_end    = row_end && (row_q >= row_lim);
		pixel_ext    = iis_pkg::ROWSUM_W'(pixel);
		row_sum_next = (col_q == '0) ? pixel_ext : (row_sum_q + pixel_ext);

		beat.valid         = take;
		beat.cmd.row_sum   = row_sum_next;
		beat.cmd.col       = col_q;
		beat.cmd.first_row = (row_q == '0);
		beat.cmd.last      = frame_end;
	end

	// Advance position and row sum on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (take) begin
			row_sum_q <= row_sum_next;
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- design/iis_cmd_queue.sv -----
// Short queue of classified pixels between the front and the back end.
// Depends on iis_pkg.
`timescale 1ns / 1ps

module iis_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  iis_pkg::cmd_beat_t wr_beat,
	output logic               full,
	input  logic               rd_en,
	output iis_pkg::cmd_t      rd_data,
	output logic               empty
);

	iis_pkg::cmd_t                 mem_q [iis_pkg::CQ_DEPTH];
	logic [iis_pkg::CQ_PTR_W-1:0]  wr_ptr_q;
	logic [iis_pkg::CQ_PTR_W-1:0]  rd_ptr_q;
	logic [iis_pkg::CQ_CNT_W-1:0]  count_q;
	logic                          do_rd;

	always_comb begin
		full    = (count_q == iis_pkg::CQ_CNT_W'(iis_pkg::CQ_DEPTH));
		empty   = (count_q == '0);
		do_rd   = rd_en && !empty;
		rd_data = mem_q[rd_ptr_q];
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_beat.valid) begin
			mem_q[wr_ptr_q] <= wr_beat.cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_beat.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_beat.valid, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/iis_back.sv -----
// Back end: reads the line store, adds the value above, writes back, queues results.
// Depends on iis_pkg and iis_ram.
`timescale 1ns / 1ps

module iis_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iis_pkg::cmd_t               cmd,
	input  logic                        cmd_empty,
	output logic                        cmd_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [iis_pkg::VALUE_W-1:0] integral_value,
	output logic                        frame_last
);

	// Stage 1: line store read data arrives
	logic                          s1_valid_s1;
	iis_pkg::cmd_t                 s1_cmd_s1;

	// Last line store write, for the same-edge collision
	logic                          fwd_valid_q;
	logic [iis_pkg::COL_W-1:0]     fwd_col_q;
	logic [iis_pkg::VALUE_W-1:0]   fwd_value_q;

	logic [iis_pkg::VALUE_W-1:0]   ram_rdata;
	logic [iis_pkg::VALUE_W-1:0]   above;
	logic [iis_pkg::VALUE_W:0]     total;
	logic [iis_pkg::VALUE_W-1:0]   result;
	logic [iis_pkg::OQ_CNT_W:0]    in_flight;

	// Result queue
	iis_pkg::res_t                 oq_mem_q [iis_pkg::OQ_DEPTH];
	logic [iis_pkg::OQ_PTR_W-1:0]  oq_wr_ptr_q;
	logic [iis_pkg::OQ_PTR_W-1:0]  oq_rd_ptr_q;
	logic [iis_pkg::OQ_CNT_W-1:0]  oq_count_q;
	logic                          oq_pop;

	// Issue only when the result queue has room for everything in flight
	always_comb begin
		in_flight = {1'b0, oq_count_q} + (iis_pkg::OQ_CNT_W + 1)'(s1_valid_s1);
		cmd_pop   = !cmd_empty &&
			(in_flight < (iis_pkg::OQ_CNT_W + 1)'(iis_pkg::OQ_DEPTH));
	end

	iis_ram #(
		.WIDTH(iis_pkg::VALUE_W),
		.DEPTH(iis_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (s1_valid_s1),
		.waddr (s1_cmd_s1.col),
		.wdata (result),
		.raddr (cmd.col),
		.rdata (ram_rdata)
	);

	// Add the value above, bypassing a write that landed on the read edge
	always_comb begin
		if (s1_cmd_s1.first_row) begin
			above = '0;
		end else if (fwd_valid_q && (fwd_col_q == s1_cmd_s1.col)) begin
			above = fwd_value_q;
		end else begin
			above = ram_rdata;
		end
		total  = (iis_pkg::VALUE_W + 1)'(s1_cmd_s1.row_sum) + {1'b0, above};
		result = total[iis_pkg::VALUE_W] ? '1 : total[iis_pkg::VALUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			s1_valid_s1 <= cmd_pop;
			fwd_valid_q <= s1_valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			s1_cmd_s1 <= cmd;
		end
		fwd_col_q   <= s1_cmd_s1.col;
		fwd_value_q <= result;
	end

	// Result queue control
	always_comb begin
		empty          = (oq_count_q == '0);
		oq_pop         = pop && !empty;
		integral_value = oq_mem_q[oq_rd_ptr_q].value;
		frame_last     = oq_mem_q[oq_rd_ptr_q].last;
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			oq_mem_q[oq_wr_ptr_q] <= '{value: result, last: s1_cmd_s1.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_ptr_q <= '0;
			oq_rd_ptr_q <= '0;
			oq_count_q  <= '0;
		end else begin
			if (s1_valid_s1) begin
				oq_wr_ptr_q <= oq_wr_ptr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_ptr_q <= oq_rd_ptr_q + 1'b1;
			end
			unique case ({s1_valid_s1, oq_pop})
				2'b10:   oq_count_q <= oq_count_q + 1'b1;
				2'b01:   oq_count_q <= oq_count_q - 1'b1;
				default: oq_count_q <= oq_count_q;
			endcase
		end
	end

endmodule

// ----- design/iis_checker.sv -----
// Port-level checks for integral_image_stream_core, attached with a bind.
// Depends on iis_pkg for widths.
`timescale 1ns / 1ps

module iis_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic [iis_pkg::VALUE_W-1:0] integral_value,
	input logic                        frame_last,
	input logic                        pready
);

	// Config port never inserts wait states
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// Input backs up only behind waiting results
	a_full_needs_results: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full with no result waiting");

	// A stalled result holds its value
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(integral_value) && $stable(frame_last)))
		else $error("stalled result changed");

	// A new result needs an earlier pushed pixel or an earlier waiting result
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		($fell(empty)) |-> $past(!empty || push, 2) || $past(!empty || push, 3)
			|| $past(!empty, 1))
		else $error("result with no input before it");

endmodule

bind integral_image_stream_core iis_checker u_iis_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.push           (push),
	.full           (full),
	.empty          (empty),
	.pop            (pop),
	.integral_value (integral_value),
	.frame_last     (frame_last),
	.pready         (pready)
);
